// File: rtl/bwt_pkg.sv
// Shared types and constants for the bone world transform / skinning block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package bwt_pkg;

    localparam int MAC_A_W   = 20;
    localparam int MAC_B_W   = 36;
    localparam int MAC_ACC_W = 58;
    localparam int SQ_IN_W   = 56;
    localparam int SQ_ROOT_W = 28;
    localparam int DIV_END_W = 44;
    localparam int DIV_Q_W   = 17;
    localparam int IDX_W     = 17;

    localparam logic CFG_ROOT_COUNT = 1'b0;
    localparam logic CFG_BONE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MAC_HOLD = 2'd0,
        MAC_CLR  = 2'd1,
        MAC_ADD  = 2'd2,
        MAC_SUB  = 2'd3
    } t_mac_op;

    // w in the top 16 bits of rot, then x, y, z
    typedef struct packed {
        logic [63:0] rot;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
    } t_bone_ent;

endpackage
`default_nettype wire

// File: rtl/bwt_mac.sv
// One multiply-accumulate lane: signed 20x36 product into a 58-bit accumulator.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwt_mac (
    input  wire                                    i_clk,
    input  bwt_pkg::t_mac_op                       i_op,
    input  wire signed [bwt_pkg::MAC_A_W-1:0]      i_a,
    input  wire signed [bwt_pkg::MAC_B_W-1:0]      i_b,
    output logic signed [bwt_pkg::MAC_ACC_W-1:0]   o_acc
);
    logic signed [bwt_pkg::MAC_A_W+bwt_pkg::MAC_B_W-1:0] w_prod;
    logic signed [bwt_pkg::MAC_ACC_W-1:0] r_acc;
    logic signed [bwt_pkg::MAC_ACC_W-1:0] w_pext;

    assign w_prod = i_a * i_b;
    assign w_pext = bwt_pkg::MAC_ACC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        case (i_op)
            bwt_pkg::MAC_CLR: r_acc <= w_pext;
            bwt_pkg::MAC_ADD: r_acc <= r_acc + w_pext;
            bwt_pkg::MAC_SUB: r_acc <= r_acc - w_pext;
            default:          r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

// File: rtl/bwt_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwt_sqrt (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire [bwt_pkg::SQ_IN_W-1:0]        i_rad,
    output logic                              o_done,
    output logic [bwt_pkg::SQ_ROOT_W-1:0]     o_root
);
    localparam int RW = bwt_pkg::SQ_ROOT_W;

    logic [bwt_pkg::SQ_IN_W-1:0] r_rad;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [RW+3:0] w_remt;
    logic [RW+3:0] w_trial;
    logic          w_ge;

    assign w_remt  = {r_rem, r_rad[bwt_pkg::SQ_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_remt >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(RW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[bwt_pkg::SQ_IN_W-3:0], 2'b00};
            r_cnt  <= r_cnt + 5'd1;
            if (w_ge) begin
                r_rem  <= (RW+2)'(w_remt - w_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_remt[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// File: rtl/bwt_div.sv
// Three restoring dividers sharing one divisor, one quotient bit per cycle.
// Quotient must fit 17 bits. Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwt_div (
    input  wire                                         i_clk,
    input  wire                                         i_rst_n,
    input  wire                                         i_start,
    input  wire [bwt_pkg::SQ_ROOT_W-1:0]                i_divisor,
    input  wire [2:0][bwt_pkg::DIV_END_W-1:0]           i_dividend,
    output logic                                        o_done,
    output logic [2:0][bwt_pkg::DIV_Q_W-1:0]            o_quot
);
    localparam int DW = bwt_pkg::SQ_ROOT_W;
    localparam int QW = bwt_pkg::DIV_Q_W;

    logic [DW-1:0]        r_div;
    logic [2:0][DW-1:0]   r_rem;
    logic [2:0][QW-1:0]   r_sh;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [2:0][DW:0]     w_remt;
    logic [2:0]           w_ge;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_remt[i] = {r_rem[i], r_sh[i][QW-1]};
            w_ge[i]   = w_remt[i] >= {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= DW'(i_dividend[i][bwt_pkg::DIV_END_W-1:QW]);
                r_sh[i]  <= i_dividend[i][QW-1:0];
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= w_ge[i] ? DW'(w_remt[i] - {1'b0, r_div}) : w_remt[i][DW-1:0];
                r_sh[i]  <= {r_sh[i][QW-2:0], w_ge[i]};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;
endmodule
`default_nettype wire

// File: rtl/bwt_mem.sv
// Bone transform store: one write port, one read port, registered read data.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bwt_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  bwt_pkg::t_bone_ent  i_wdata,
    input  wire                 i_re,
    input  wire [AW-1:0]        i_raddr,
    output bwt_pkg::t_bone_ent  o_rdata
);
    bwt_pkg::t_bone_ent r_mem [DEPTH];
    bwt_pkg::t_bone_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/bone_world_transform_vertex_skinning.sv
// Top level: sequencer around the bone store, four MAC lanes, square root and divider.
// Depends on bwt_pkg, bwt_mac, bwt_sqrt, bwt_div, bwt_mem.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | i_in_valid/o_in_ready, opcode..bone_select | in
//   out     | o_out_valid/i_out_ready, out_pos..was_tr.  | out
//   cfg     | i_cfg_valid/o_cfg_ready, index, data       | in
//
// One item at a time. The 28-step square root and 17-step divide take most of the time
// of a bone load or a vertex; rotations run on the MAC lanes.
// Sync active-low reset, no clearing pass: store data is only used where written.
// Input is taken while a finished word still waits on the output register.
`timescale 1ns / 1ps
`default_nettype none
module bone_world_transform_vertex_skinning #(
    parameter int BONE_SLOTS = 256
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_opcode,
    input  wire signed [7:0]    i_parent_index,
    input  wire signed [15:0]   i_rot_x,
    input  wire signed [15:0]   i_rot_y,
    input  wire signed [15:0]   i_rot_z,
    input  wire signed [31:0]   i_pos_x,
    input  wire signed [31:0]   i_pos_y,
    input  wire signed [31:0]   i_pos_z,
    input  wire signed [15:0]   i_nrm_x,
    input  wire signed [15:0]   i_nrm_y,
    input  wire signed [15:0]   i_nrm_z,
    input  wire [15:0]          i_bone_select,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic signed [31:0]  o_out_pos_x,
    output logic signed [31:0]  o_out_pos_y,
    output logic signed [31:0]  o_out_pos_z,
    output logic signed [15:0]  o_out_nrm_x,
    output logic signed [15:0]  o_out_nrm_y,
    output logic signed [15:0]  o_out_nrm_z,
    output logic                o_was_transformed,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire [8:0]           i_cfg_data
);
    localparam int AW = $clog2(BONE_SLOTS);
    localparam int IW = bwt_pkg::IDX_W;
    localparam logic [IW-1:0] SLOTS_W = IW'(BONE_SLOTS);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_SQSUM = 9'b000000100,
        ST_SQRT  = 9'b000001000,
        ST_ROT   = 9'b000010000,
        ST_QMUL  = 9'b000100000,
        ST_WRITE = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [44:0] v);
        if (v > 45'sd2147483647) return 32'sh7fffffff;
        else if (v < -45'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [57:0] v);
        if (v > 58'sd32767) return 16'sh7fff;
        else if (v < -58'sd32768) return 16'sh8000;
        else return v[15:0];
    endfunction

    t_state r_state, n_state;
    logic [8:0] r_root, r_bone, r_loaded;
    logic [2:0] r_step;
    logic       r_vtx, r_pass, r_apply, r_in_range;
    logic [AW-1:0] r_slot;
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_nrm [3];
    logic signed [15:0] r_rot [3];
    logic signed [15:0] r_lw;
    logic signed [35:0] r_t [3];
    logic signed [43:0] r_res [3];
    logic signed [31:0] r_wt [3];
    logic signed [19:0] r_rn [3];
    logic signed [15:0] r_wq [4];
    logic signed [15:0] r_nq [3];

    logic w_acc_in, w_acc_out;
    logic [IW-1:0] w_slot, w_end, w_bsel, w_par, w_root, w_loaded_end;
    logic w_load_ok, w_par_ok, w_in_range, w_moved;

    bwt_pkg::t_bone_ent w_rdata, w_wdata;
    logic w_re, w_we;
    logic [AW-1:0] w_raddr;

    logic signed [15:0] w_q [4];
    logic signed [35:0] w_v [3];
    logic signed [31:0] w_sh [3];
    logic signed [bwt_pkg::MAC_A_W-1:0]   w_a [4];
    logic signed [bwt_pkg::MAC_B_W-1:0]   w_b [4];
    bwt_pkg::t_mac_op                     w_op [4];
    logic signed [bwt_pkg::MAC_ACC_W-1:0] w_acc [4];

    logic [43:0] w_sqsum;
    logic signed [44:0] w_ww;
    logic [bwt_pkg::SQ_IN_W-1:0] w_rad;
    logic w_sq_start, w_sq_done;
    logic [bwt_pkg::SQ_ROOT_W-1:0] w_root_out;
    logic w_div_start, w_div_done;
    logic [2:0][bwt_pkg::DIV_END_W-1:0] w_dividend;
    logic [2:0][bwt_pkg::DIV_Q_W-1:0]   w_quot;
    logic [19:0] w_mag [3];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign w_acc_out   = !o_out_valid || i_out_ready;

    // slot / range bookkeeping
    assign w_root       = IW'(r_root);
    assign w_slot       = w_root + IW'(r_loaded);
    assign w_end        = (w_root + IW'(r_bone) > SLOTS_W) ? SLOTS_W : w_root + IW'(r_bone);
    assign w_bsel       = IW'(i_bone_select);
    assign w_par        = IW'(i_parent_index[6:0]);
    assign w_loaded_end = w_slot;
    assign w_load_ok    = (r_loaded < r_bone) && (w_slot < SLOTS_W);
    assign w_par_ok     = !i_parent_index[7] && (w_par >= w_root) && (w_par < w_slot);
    assign w_in_range   = w_bsel < w_end;
    assign w_moved      = w_in_range && (w_bsel >= w_root) && (w_bsel < w_loaded_end);

    assign w_re    = w_acc_in;
    assign w_raddr = i_opcode ? w_bsel[AW-1:0] : w_par[AW-1:0];
    assign w_we    = (r_state == ST_WRITE);
    assign w_wdata = '{rot: {r_wq[0], r_wq[1], r_wq[2], r_wq[3]},
                       sx: r_wt[0], sy: r_wt[1], sz: r_wt[2]};

    bwt_mem #(.DEPTH(BONE_SLOTS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_q[0] = w_rdata.rot[63:48];
    assign w_q[1] = w_rdata.rot[47:32];
    assign w_q[2] = w_rdata.rot[31:16];
    assign w_q[3] = w_rdata.rot[15:0];
    assign w_sh[0] = w_rdata.sx;
    assign w_sh[1] = w_rdata.sy;
    assign w_sh[2] = w_rdata.sz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = r_pass ? 36'(r_nrm[i]) : 36'(r_pos[i]);
        end
    end

    // lane operand selection; lane 3 only serves the w term of the quaternion product
    always_comb begin
        int j;
        int k;
        for (int i = 0; i < 4; i++) begin
            w_a[i]  = '0;
            w_b[i]  = '0;
            w_op[i] = bwt_pkg::MAC_HOLD;
        end
        for (int i = 0; i < 3; i++) begin
            j = (i == 2) ? 0 : i + 1;
            k = (i == 0) ? 2 : i - 1;
            case (r_state)
                ST_SQ: begin
                    w_op[i] = bwt_pkg::MAC_CLR;
                    w_a[i]  = r_vtx ? r_rn[i] : 20'(r_rot[i]);
                    w_b[i]  = r_vtx ? 36'(r_rn[i]) : 36'(r_rot[i]);
                end
                ST_ROT: begin
                    case (r_step)
                        3'd0: begin
                            w_op[i] = bwt_pkg::MAC_CLR;
                            w_a[i] = 20'(w_q[j+1]); w_b[i] = w_v[k];
                        end
                        3'd1: begin
                            w_op[i] = bwt_pkg::MAC_SUB;
                            w_a[i] = 20'(w_q[k+1]); w_b[i] = w_v[j];
                        end
                        3'd3: begin
                            w_op[i] = bwt_pkg::MAC_CLR;
                            w_a[i] = 20'(w_q[0]); w_b[i] = r_t[i];
                        end
                        3'd4: begin
                            w_op[i] = bwt_pkg::MAC_ADD;
                            w_a[i] = 20'(w_q[j+1]); w_b[i] = r_t[k];
                        end
                        3'd5: begin
                            w_op[i] = bwt_pkg::MAC_SUB;
                            w_a[i] = 20'(w_q[k+1]); w_b[i] = r_t[j];
                        end
                        default: w_op[i] = bwt_pkg::MAC_HOLD;
                    endcase
                end
                ST_QMUL: begin
                    case (r_step)
                        3'd0: begin
                            w_op[i] = bwt_pkg::MAC_CLR;
                            w_a[i] = 20'(w_q[0]); w_b[i] = 36'(r_rot[i]);
                        end
                        3'd1: begin
                            w_op[i] = bwt_pkg::MAC_ADD;
                            w_a[i] = 20'(w_q[i+1]); w_b[i] = 36'(r_lw);
                        end
                        3'd2: begin
                            w_op[i] = bwt_pkg::MAC_ADD;
                            w_a[i] = 20'(w_q[j+1]); w_b[i] = 36'(r_rot[k]);
                        end
                        3'd3: begin
                            w_op[i] = bwt_pkg::MAC_SUB;
                            w_a[i] = 20'(w_q[k+1]); w_b[i] = 36'(r_rot[j]);
                        end
                        default: w_op[i] = bwt_pkg::MAC_HOLD;
                    endcase
                end
                default: w_op[i] = bwt_pkg::MAC_HOLD;
            endcase
        end
        if (r_state == ST_QMUL) begin
            case (r_step)
                3'd0: begin
                    w_op[3] = bwt_pkg::MAC_CLR;
                    w_a[3] = 20'(w_q[0]); w_b[3] = 36'(r_lw);
                end
                3'd1, 3'd2, 3'd3: begin
                    w_op[3] = bwt_pkg::MAC_SUB;
                    w_a[3] = 20'(w_q[r_step[1:0]]); w_b[3] = 36'(r_rot[r_step[1:0] - 2'd1]);
                end
                default: w_op[3] = bwt_pkg::MAC_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        bwt_mac u_mac (
            .i_clk (i_clk),
            .i_op  (w_op[g]),
            .i_a   (w_a[g]),
            .i_b   (w_b[g]),
            .o_acc (w_acc[g])
        );
    end

    // sum of squares: 2^30 - |xyz|^2 for w rebuild, or |n|^2 for the normal
    assign w_sqsum = 44'(w_acc[0][41:0]) + 44'(w_acc[1][41:0]) + 44'(w_acc[2][41:0]);
    assign w_ww    = 45'sd1073741824 - $signed({1'b0, w_sqsum});
    assign w_rad   = r_vtx ? {w_sqsum[39:0], 16'b0}
                           : (w_ww[44] ? '0 : bwt_pkg::SQ_IN_W'(w_ww[43:0]));
    assign w_sq_start = (r_state == ST_SQSUM) && !(r_vtx && w_sqsum == '0);

    bwt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_rad),
        .o_done  (w_sq_done),
        .o_root  (w_root_out)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_rn[i][19] ? 20'(-r_rn[i]) : 20'(r_rn[i]);
            w_dividend[i] = 44'({w_mag[i], 23'b0}) + 44'(w_root_out[bwt_pkg::SQ_ROOT_W-1:1]);
        end
    end
    assign w_div_start = (r_state == ST_SQRT) && w_sq_done && r_vtx;

    bwt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_divisor  (w_root_out),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in) begin
                    if (i_opcode) n_state = w_moved ? ST_ROT : ST_SQ;
                    else if (w_load_ok) n_state = ST_SQ;
                end
            end
            ST_SQ:    n_state = ST_SQSUM;
            ST_SQSUM: n_state = (r_vtx && w_sqsum == '0) ? ST_DONE : ST_SQRT;
            ST_SQRT: begin
                if (w_sq_done) begin
                    if (r_vtx) n_state = ST_DIV;
                    else n_state = r_apply ? ST_ROT : ST_WRITE;
                end
            end
            ST_ROT: begin
                if (r_step == 3'd7) begin
                    if (!r_vtx) n_state = ST_QMUL;
                    else if (r_pass) n_state = ST_SQ;
                end
            end
            ST_QMUL:  if (r_step == 3'd4) n_state = ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            ST_DIV:   if (w_div_done) n_state = ST_DONE;
            ST_DONE:  if (w_acc_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_root   <= '0;
            r_bone   <= '0;
            r_loaded <= '0;
            r_step   <= '0;
            r_pass   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                if (i_cfg_index == bwt_pkg::CFG_ROOT_COUNT) r_root <= i_cfg_data;
                if (i_cfg_index == bwt_pkg::CFG_BONE_COUNT) r_bone <= i_cfg_data;
                r_loaded <= '0;
            end else if (r_state == ST_WRITE) begin
                r_loaded <= r_loaded + 9'd1;
            end
            // step wraps 7 -> 0 between the position and normal passes
            if (r_state != n_state) r_step <= '0;
            else if (r_state == ST_ROT || r_state == ST_QMUL) r_step <= r_step + 3'd1;
            if (r_state == ST_IDLE) r_pass <= 1'b0;
            else if (r_state == ST_ROT && r_step == 3'd7) r_pass <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_vtx      <= i_opcode;
            r_apply    <= w_par_ok;
            r_in_range <= w_in_range;
            r_slot     <= w_slot[AW-1:0];
            r_pos[0] <= i_pos_x; r_pos[1] <= i_pos_y; r_pos[2] <= i_pos_z;
            r_nrm[0] <= i_nrm_x; r_nrm[1] <= i_nrm_y; r_nrm[2] <= i_nrm_z;
            r_rot[0] <= i_rot_x; r_rot[1] <= i_rot_y; r_rot[2] <= i_rot_z;
            if (!i_opcode || !w_moved) begin
                r_wt[0] <= i_pos_x; r_wt[1] <= i_pos_y; r_wt[2] <= i_pos_z;
                r_rn[0] <= 20'(i_nrm_x); r_rn[1] <= 20'(i_nrm_y); r_rn[2] <= 20'(i_nrm_z);
            end
        end
        if (r_state == ST_SQSUM && r_vtx && w_sqsum == '0) begin
            for (int i = 0; i < 3; i++) r_nq[i] <= '0;
        end
        if (r_state == ST_SQRT && w_sq_done && !r_vtx) begin
            r_lw <= (w_root_out > 28'd32767) ? 16'sh7fff : w_root_out[15:0];
            r_wq[0] <= (w_root_out > 28'd32767) ? 16'sh7fff : w_root_out[15:0];
            for (int i = 0; i < 3; i++) r_wq[i+1] <= r_rot[i];
        end
        if (r_state == ST_ROT) begin
            for (int i = 0; i < 3; i++) begin
                if (r_step == 3'd2)
                    r_t[i] <= 36'(((w_acc[i] <<< 1) + 58'sd16384) >>> 15);
                if (r_step == 3'd6)
                    r_res[i] <= 44'(w_v[i]) + 44'((w_acc[i] + 58'sd16384) >>> 15);
                if (r_step == 3'd7) begin
                    if (r_pass) r_rn[i] <= r_res[i][19:0];
                    else r_wt[i] <= f_sat32(45'(r_res[i]) + 45'(w_sh[i]));
                end
            end
        end
        if (r_state == ST_QMUL && r_step == 3'd4) begin
            for (int i = 0; i < 3; i++)
                r_wq[i+1] <= f_sat16((w_acc[i] + 58'sd16384) >>> 15);
            r_wq[0] <= f_sat16((w_acc[3] + 58'sd16384) >>> 15);
        end
        if (r_state == ST_DIV && w_div_done) begin
            for (int i = 0; i < 3; i++) begin
                if (r_rn[i][19])
                    r_nq[i] <= w_quot[i][16] ? 16'sh8000 : 16'(-$signed({1'b0, w_quot[i]}));
                else
                    r_nq[i] <= (w_quot[i] > 17'd32767) ? 16'sh7fff : w_quot[i][15:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_acc_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_acc_out) begin
            o_out_pos_x <= r_wt[0];
            o_out_pos_y <= r_wt[1];
            o_out_pos_z <= r_wt[2];
            o_out_nrm_x <= r_nq[0];
            o_out_nrm_y <= r_nq[1];
            o_out_nrm_z <= r_nq[2];
            o_was_transformed <= r_in_range;
        end
    end
endmodule
`default_nettype wire
